@@ src/sle_pkg.sv @@
// ============================================================================
// sle_pkg
// Shared types, codes and default sizes for the sequential list engine.
// ============================================================================
package sle_pkg;

    // Default list depth (entries)
    localparam int DEPTH_DEF = 64;

    // Field widths
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 8;
    localparam int STAT_W = 3;

    // Command codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
    localparam logic [OP_W-1:0] OP_PURGE  = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    // One result item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  found_index;
        logic [POS_W-1:0]  length;
        logic              is_empty;
    } rsp_t;

    // Memory access request from the sequencer (addresses sized for the
    // largest depth; the memory uses the low bits it needs)
    typedef struct packed {
        logic              we;
        logic [POS_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [POS_W-1:0]  raddr;
    } mem_req_t;

endpackage

@@ src/sle_if.sv @@
// ============================================================================
// sle_if
// Valid/ready channel interfaces: command items in, result items out.
// ============================================================================
interface sle_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [sle_pkg::OP_W-1:0]            opcode;
    logic signed [sle_pkg::DATA_W-1:0]   value;
    logic [sle_pkg::POS_W-1:0]           position;

    modport source (output valid, output opcode, output value, output position,
                    input ready);
    modport sink   (input valid, input opcode, input value, input position,
                    output ready);
endinterface

interface sle_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [sle_pkg::STAT_W-1:0]  status;
    logic [sle_pkg::POS_W-1:0]   found_index;
    logic [sle_pkg::POS_W-1:0]   length;
    logic                        is_empty;

    modport source (output valid, output status, output found_index,
                    output length, output is_empty, input ready);
    modport sink   (input valid, input status, input found_index,
                    input length, input is_empty, output ready);
endinterface

@@ src/sle_mem.sv @@
// ============================================================================
// sle_mem
// Entry storage: one write port, one read port with registered read data.
// ============================================================================
module sle_mem #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input  logic                       clk,
    input  sle_pkg::mem_req_t          req,
    output logic [sle_pkg::DATA_W-1:0] rdata
);
    localparam int AW = $clog2(DEPTH);

    logic [sle_pkg::DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr[AW-1:0]];
        end
    end

endmodule

@@ src/sle_seq.sv @@
// ============================================================================
// sle_seq
// Command sequencer: walks the entry memory one access at a time, sharing a
// single equality compare for locate and purge.
// ============================================================================
module sle_seq #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sle_pkg::OP_W-1:0]          opcode,
    input  logic signed [sle_pkg::DATA_W-1:0] value,
    input  logic [sle_pkg::POS_W-1:0]         position,
    input  logic                              out_free,
    output logic                              done,
    output sle_pkg::rsp_t                     result,
    output sle_pkg::mem_req_t                 mem_req,
    input  logic [sle_pkg::DATA_W-1:0]        mem_rdata
);
    localparam int CW = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INRD  = 4'd1;
    localparam logic [3:0] S_INWR  = 4'd2;
    localparam logic [3:0] S_INSW  = 4'd3;
    localparam logic [3:0] S_RMCHK = 4'd4;
    localparam logic [3:0] S_RMWR  = 4'd5;
    localparam logic [3:0] S_LCHK  = 4'd6;
    localparam logic [3:0] S_LCMP  = 4'd7;
    localparam logic [3:0] S_PCHK  = 4'd8;
    localparam logic [3:0] S_PCUR  = 4'd9;
    localparam logic [3:0] S_PJRD  = 4'd10;
    localparam logic [3:0] S_PJCMP = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]                  state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               k_reg, k_next;
    logic [CW-1:0]               i_reg, i_next;
    logic [sle_pkg::OP_W-1:0]    op_reg, op_next;
    logic [sle_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [sle_pkg::DATA_W-1:0]  cur_reg, cur_next;
    logic [sle_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [sle_pkg::POS_W-1:0]   found_reg, found_next;

    logic [sle_pkg::POS_W-1:0]   cnt8;
    logic [CW-1:0]               k_dec;
    logic                        hit;

    assign cnt8  = sle_pkg::POS_W'(count_reg);
    assign k_dec = k_reg - CW'(1);
    // shared compare unit
    assign hit   = (mem_rdata == cur_reg);

    assign in_ready = (state_reg == S_IDLE);

    // result fields
    assign result.status      = status_reg;
    assign result.found_index = found_reg;
    assign result.length      = cnt8;
    assign result.is_empty    = (count_reg == '0);

    // next-state and memory access logic
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        status_next = status_reg;
        found_next  = found_reg;
        done        = 1'b0;
        mem_req     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = opcode;
                    pos_next    = position;
                    cur_next    = value;
                    status_next = sle_pkg::ST_OK;
                    found_next  = '0;
                    state_next  = S_DONE;
                    case (opcode)
                        sle_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        sle_pkg::OP_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                                status_next = sle_pkg::ST_FULL;
                            else if (position > cnt8)
                                status_next = sle_pkg::ST_BADPOS;
                            else if (cnt8 > position)
                            begin
                                k_next     = count_reg;
                                state_next = S_INRD;
                            end
                            else
                                state_next = S_INSW;
                        end
                        sle_pkg::OP_DELETE:
                        begin
                            if (count_reg == '0)
                                status_next = sle_pkg::ST_EMPTY;
                            else if (position >= cnt8)
                                status_next = sle_pkg::ST_BADPOS;
                            else
                            begin
                                k_next     = CW'(position) + CW'(1);
                                state_next = S_RMCHK;
                            end
                        end
                        sle_pkg::OP_LOCATE:
                        begin
                            k_next     = '0;
                            state_next = S_LCHK;
                        end
                        sle_pkg::OP_PURGE:
                        begin
                            i_next     = CW'(1);
                            state_next = S_PCHK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // insert: move entry k-1 up to k
            S_INRD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = sle_pkg::POS_W'(k_dec);
                state_next    = S_INWR;
            end
            S_INWR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = sle_pkg::POS_W'(k_reg);
                mem_req.wdata = mem_rdata;
                k_next        = k_dec;
                if (sle_pkg::POS_W'(k_dec) > pos_reg)
                    state_next = S_INRD;
                else
                    state_next = S_INSW;
            end
            S_INSW:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = cur_reg;
                count_next    = count_reg + CW'(1);
                state_next    = S_DONE;
            end

            // remove: move entry k down to k-1 until the end
            S_RMCHK:
            begin
                if (k_reg < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = sle_pkg::POS_W'(k_reg);
                    state_next    = S_RMWR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = (op_reg == sle_pkg::OP_PURGE) ? S_PCHK : S_DONE;
                end
            end
            S_RMWR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = sle_pkg::POS_W'(k_dec);
                mem_req.wdata = mem_rdata;
                k_next        = k_reg + CW'(1);
                state_next    = S_RMCHK;
            end

            // locate: linear scan from the head
            S_LCHK:
            begin
                if (k_reg < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = sle_pkg::POS_W'(k_reg);
                    state_next    = S_LCMP;
                end
                else
                begin
                    status_next = sle_pkg::ST_NOTFOUND;
                    state_next  = S_DONE;
                end
            end
            S_LCMP:
            begin
                if (hit)
                begin
                    found_next = sle_pkg::POS_W'(k_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = S_LCHK;
                end
            end

            // purge: fetch entry i, compare it against the earlier entries and delete it on a match
            S_PCHK:
            begin
                if (i_reg < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = sle_pkg::POS_W'(i_reg);
                    state_next    = S_PCUR;
                end
                else
                    state_next = S_DONE;
            end
            S_PCUR:
            begin
                cur_next   = mem_rdata;
                k_next     = '0;
                state_next = S_PJRD;
            end
            S_PJRD:
            begin
                if (k_reg < i_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = sle_pkg::POS_W'(k_reg);
                    state_next    = S_PJCMP;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_PCHK;
                end
            end
            S_PJCMP:
            begin
                if (hit)
                begin
                    k_next     = i_reg + CW'(1);
                    state_next = S_RMCHK;
                end
                else
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = S_PJRD;
                end
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        i_reg      <= i_next;
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start");

    a_dup_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PJCMP) |-> (k_reg < i_reg))
        else $error("duplicate scan past current entry");

    a_shift_up: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INWR) |-> (sle_pkg::POS_W'(k_reg) > pos_reg))
        else $error("insert shift below position");

endmodule

@@ src/sequential_list_engine_unit.sv @@
// ============================================================================
// sequential_list_engine_unit
// Ordered list of signed words with clear, insert, delete, locate and purge.
// ============================================================================
//  channel | dir | handshake     | payload
//  cmd     | in  | valid / ready | opcode, value, position
//  rsp     | out | valid / ready | status, found_index, length, is_empty
//
//  One command at a time; cmd.ready is high only while the sequencer waits.
//  Entry memory has one read and one write port: each entry moved takes a
//  read and a write; each entry compared takes a read and then a compare.
//  Reset empties the list; entry contents are not cleared.
//  A result waits in the output register; the next command is accepted
//  meanwhile, and the sequencer holds its own result while that register is full.
// ============================================================================
module sequential_list_engine_unit #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sle_cmd_if.sink   cmd,
    sle_rsp_if.source rsp
);
    sle_pkg::mem_req_t          mem_req;
    logic [sle_pkg::DATA_W-1:0] mem_rdata;
    sle_pkg::rsp_t              seq_result;
    logic                       seq_done;
    logic                       out_free;

    logic                       out_valid_reg, out_valid_next;
    sle_pkg::rsp_t              out_data_reg;

    sle_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .opcode    (cmd.opcode),
        .value     (cmd.value),
        .position  (cmd.position),
        .out_free  (out_free),
        .done      (seq_done),
        .result    (seq_result),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    sle_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // output register
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (seq_done)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (seq_done)
            out_data_reg <= seq_result;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_data_reg.status;
    assign rsp.found_index = out_data_reg.found_index;
    assign rsp.length      = out_data_reg.length;
    assign rsp.is_empty    = out_data_reg.is_empty;

endmodule
